// ===== hdl/pva_pkg.sv =====
// shared types, widths and codes for the voice allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pva_pkg;

    localparam int NUM_VOICES = 8;
    localparam int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int MASK_N     = (NUM_VOICES < 8) ? NUM_VOICES : 8;

    localparam int KIND_W  = 2;
    localparam int CH_W    = 4;
    localparam int NOTE_W  = 7;
    localparam int OIDX_W  = 3;
    localparam int SRC_W   = 3;
    localparam int MASK_W  = 8;
    localparam int ENV_W   = 17;
    localparam int PROD_W  = 2 * ENV_W;
    localparam int SUM_W   = PROD_W + 16;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [ENV_W-1:0] ONE_FX = 17'h10000;

    localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK     = 2'd2;

    localparam logic [SRC_W-1:0] SRC_NONE      = 3'd0;
    localparam logic [SRC_W-1:0] SRC_RETRIGGER = 3'd1;
    localparam logic [SRC_W-1:0] SRC_FREE      = 3'd2;
    localparam logic [SRC_W-1:0] SRC_STOLE_REL = 3'd3;
    localparam logic [SRC_W-1:0] SRC_STOLE_SND = 3'd4;

    localparam logic [1:0] REG_ATTACK_STEP  = 2'd0;
    localparam logic [1:0] REG_RELEASE_STEP = 2'd1;
    localparam logic [1:0] REG_END_THR      = 2'd2;
    localparam logic [1:0] REG_RESTART_THR  = 2'd3;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_SCAN_ON,
        DP_CLAIM,
        DP_SCAN_OFF,
        DP_TICK_RD,
        DP_TICK_SQ,
        DP_TICK_LO,
        DP_TICK_HI,
        DP_TICK_WR
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [VIDX_W-1:0]   idx;
        logic                publish;
    } pva_cmd_t;

    typedef struct packed {
        logic need_mul;
    } pva_status_t;

    typedef struct packed {
        logic [ENV_W-1:0] attack_step;
        logic [ENV_W-1:0] release_step;
        logic [ENV_W-1:0] end_threshold;
        logic [ENV_W-1:0] restart_threshold;
    } pva_cfg_t;

endpackage

`default_nettype wire

// ===== hdl/pva_ctrl.sv =====
// sequencer for the voice allocator: walks voices one per cycle,
// holding for each fading voice's multiply; depends on pva_pkg
`timescale 1ns / 1ps
`default_nettype none

module pva_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_take,
    input  wire logic [pva_pkg::KIND_W-1:0]  in_kind,
    input  wire logic                        out_free,
    input  wire pva_pkg::pva_status_t        status,
    output logic                             idle,
    output pva_pkg::pva_cmd_t                cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ON_SCAN,
        ST_ON_CLAIM,
        ST_OFF_SCAN,
        ST_TK_RD,
        ST_TK_SQ,
        ST_TK_LO,
        ST_TK_HI,
        ST_TK_WR,
        ST_FINISH
    } state_t;

    localparam logic [pva_pkg::VIDX_W-1:0] LAST_IDX = pva_pkg::VIDX_W'(pva_pkg::NUM_VOICES - 1);

    state_t                        state_reg;
    logic [pva_pkg::VIDX_W-1:0]    idx_reg;
    logic                          last;

    assign last = (idx_reg == LAST_IDX);
    assign idle = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    idx_reg <= '0;
                    if (in_take) begin
                        unique case (in_kind)
                            pva_pkg::KIND_NOTE_ON:  state_reg <= ST_ON_SCAN;
                            pva_pkg::KIND_NOTE_OFF: state_reg <= ST_OFF_SCAN;
                            pva_pkg::KIND_TICK:     state_reg <= ST_TK_RD;
                            default:                state_reg <= ST_FINISH;
                        endcase
                    end
                end
                ST_ON_SCAN: begin
                    if (last) state_reg <= ST_ON_CLAIM;
                    else idx_reg <= idx_reg + 1'b1;
                end
                ST_ON_CLAIM: state_reg <= ST_FINISH;
                ST_OFF_SCAN: begin
                    if (last) state_reg <= ST_FINISH;
                    else idx_reg <= idx_reg + 1'b1;
                end
                ST_TK_RD: begin
                    if (status.need_mul) state_reg <= ST_TK_SQ;
                    else if (last) state_reg <= ST_FINISH;
                    else idx_reg <= idx_reg + 1'b1;
                end
                ST_TK_SQ: state_reg <= ST_TK_LO;
                ST_TK_LO: state_reg <= ST_TK_HI;
                ST_TK_HI: state_reg <= ST_TK_WR;
                ST_TK_WR: begin
                    if (last) state_reg <= ST_FINISH;
                    else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_TK_RD;
                    end
                end
                ST_FINISH: begin
                    if (out_free) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        cmd.idx     = idx_reg;
        cmd.publish = 1'b0;
        unique case (state_reg)
            ST_IDLE:     cmd.op = in_take ? pva_pkg::DP_LOAD : pva_pkg::DP_NOP;
            ST_ON_SCAN:  cmd.op = pva_pkg::DP_SCAN_ON;
            ST_ON_CLAIM: cmd.op = pva_pkg::DP_CLAIM;
            ST_OFF_SCAN: cmd.op = pva_pkg::DP_SCAN_OFF;
            ST_TK_RD:    cmd.op = pva_pkg::DP_TICK_RD;
            ST_TK_SQ:    cmd.op = pva_pkg::DP_TICK_SQ;
            ST_TK_LO:    cmd.op = pva_pkg::DP_TICK_LO;
            ST_TK_HI:    cmd.op = pva_pkg::DP_TICK_HI;
            ST_TK_WR:    cmd.op = pva_pkg::DP_TICK_WR;
            ST_FINISH: begin
                cmd.op      = pva_pkg::DP_NOP;
                cmd.publish = out_free;
            end
            default:     cmd.op = pva_pkg::DP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/pva_datapath.sv =====
// voice store, allocation trackers and shared envelope multiplier
// depends on pva_pkg
`timescale 1ns / 1ps
`default_nettype none

module pva_datapath (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire pva_pkg::pva_cmd_t           cmd,
    input  wire pva_pkg::pva_cfg_t           cfg,
    input  wire logic [pva_pkg::CH_W-1:0]    in_channel,
    input  wire logic [pva_pkg::NOTE_W-1:0]  in_note,
    output pva_pkg::pva_status_t             status,
    output logic [pva_pkg::OIDX_W-1:0]       res_index,
    output logic [pva_pkg::SRC_W-1:0]        res_source,
    output logic [pva_pkg::MASK_W-1:0]       res_mask
);

    localparam int N  = pva_pkg::NUM_VOICES;
    localparam int IW = pva_pkg::VIDX_W;
    localparam int EW = pva_pkg::ENV_W;
    localparam int PW = pva_pkg::PROD_W;

    // voice state
    logic                         act_reg   [N];
    logic                         rel_reg   [N];
    logic [EW-1:0]                env_reg   [N];
    logic [EW-1:0]                lvl_reg   [N];
    logic [EW-1:0]                prog_reg  [N];
    logic [pva_pkg::NOTE_W-1:0]   note_reg  [N];
    logic [pva_pkg::CH_W-1:0]     ch_reg    [N];

    // current item
    logic [pva_pkg::NOTE_W-1:0]   cur_note_reg;
    logic [pva_pkg::CH_W-1:0]     cur_ch_reg;

    // note-on trackers
    logic            fm_reg, ff_reg, fr_reg, fa_reg;
    logic [IW-1:0]   m_idx_reg, f_idx_reg, r_idx_reg, a_idx_reg;
    logic [EW-1:0]   f_env_reg, r_env_reg, a_env_reg;

    // multiplier pipeline
    logic [EW-1:0]   d_reg;
    logic [PW-1:0]   prod_reg;
    logic [EW-1:0]   sq_hi_reg;
    logic [PW-2:0]   lo_reg;

    logic [pva_pkg::OIDX_W-1:0] res_index_reg;
    logic [pva_pkg::SRC_W-1:0]  res_source_reg;

    logic [IW-1:0]   ix;
    logic            rd_act, rd_rel, rd_match;
    logic [EW-1:0]   rd_env, rd_lvl, rd_prog;
    logic [EW:0]     att_sum, prog_sum;
    logic [EW-1:0]   att_env, p_new;
    logic [EW-1:0]   mul_a, mul_b;
    logic [PW-1:0]   mul_p;
    logic [pva_pkg::SUM_W-1:0] rel_sum;
    logic [EW-1:0]   rel_env;
    logic [IW-1:0]   sel;
    logic [pva_pkg::SRC_W-1:0] sel_src;
    logic [EW-1:0]   sel_env;

    assign ix       = cmd.idx;
    assign rd_act   = act_reg[ix];
    assign rd_rel   = rel_reg[ix];
    assign rd_env   = env_reg[ix];
    assign rd_lvl   = lvl_reg[ix];
    assign rd_prog  = prog_reg[ix];
    assign rd_match = rd_act && (note_reg[ix] == cur_note_reg) && (ch_reg[ix] == cur_ch_reg);

    assign att_sum  = {1'b0, rd_env} + {1'b0, cfg.attack_step};
    assign att_env  = (att_sum > {1'b0, pva_pkg::ONE_FX}) ? pva_pkg::ONE_FX : att_sum[EW-1:0];
    assign prog_sum = {1'b0, rd_prog} + {1'b0, cfg.release_step};
    assign p_new    = (prog_sum > {1'b0, pva_pkg::ONE_FX}) ? pva_pkg::ONE_FX : prog_sum[EW-1:0];

    assign status.need_mul = rd_act && rd_rel && (p_new != pva_pkg::ONE_FX);

    // one shared 17x17 multiplier: d*d, then level times each half of d*d
    always_comb begin
        unique case (cmd.op)
            pva_pkg::DP_TICK_SQ: begin
                mul_a = d_reg;
                mul_b = d_reg;
            end
            pva_pkg::DP_TICK_LO: begin
                mul_a = rd_lvl;
                mul_b = {1'b0, prod_reg[15:0]};
            end
            default: begin
                mul_a = rd_lvl;
                mul_b = sq_hi_reg;
            end
        endcase
    end
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    assign rel_sum = {prod_reg, 16'b0} + pva_pkg::SUM_W'(lo_reg);
    assign rel_env = rel_sum[48:32];

    always_comb begin
        if (fm_reg) begin
            sel = m_idx_reg; sel_src = pva_pkg::SRC_RETRIGGER; sel_env = '0;
        end else if (ff_reg) begin
            sel = f_idx_reg; sel_src = pva_pkg::SRC_FREE; sel_env = f_env_reg;
        end else if (fr_reg) begin
            sel = r_idx_reg; sel_src = pva_pkg::SRC_STOLE_REL; sel_env = r_env_reg;
        end else begin
            sel = a_idx_reg; sel_src = pva_pkg::SRC_STOLE_SND; sel_env = a_env_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) begin
                act_reg[i]  <= 1'b0;
                rel_reg[i]  <= 1'b0;
                env_reg[i]  <= '0;
                lvl_reg[i]  <= '0;
                prog_reg[i] <= '0;
            end
            fm_reg <= 1'b0; ff_reg <= 1'b0; fr_reg <= 1'b0; fa_reg <= 1'b0;
            res_index_reg  <= '0;
            res_source_reg <= pva_pkg::SRC_NONE;
        end else begin
            unique case (cmd.op)
                pva_pkg::DP_LOAD: begin
                    cur_note_reg   <= in_note;
                    cur_ch_reg     <= in_channel;
                    fm_reg <= 1'b0; ff_reg <= 1'b0; fr_reg <= 1'b0; fa_reg <= 1'b0;
                    res_index_reg  <= '0;
                    res_source_reg <= pva_pkg::SRC_NONE;
                end
                pva_pkg::DP_SCAN_ON: begin
                    if (rd_match && !fm_reg) begin
                        fm_reg <= 1'b1; m_idx_reg <= ix;
                    end
                    if (!rd_act && !ff_reg) begin
                        ff_reg <= 1'b1; f_idx_reg <= ix; f_env_reg <= rd_env;
                    end
                    if (rd_rel && (!fr_reg || rd_env < r_env_reg)) begin
                        fr_reg <= 1'b1; r_idx_reg <= ix; r_env_reg <= rd_env;
                    end
                    if (!fa_reg || rd_env < a_env_reg) begin
                        fa_reg <= 1'b1; a_idx_reg <= ix; a_env_reg <= rd_env;
                    end
                end
                pva_pkg::DP_CLAIM: begin
                    res_index_reg  <= pva_pkg::OIDX_W'(sel);
                    res_source_reg <= sel_src;
                    rel_reg[sel]   <= 1'b0;
                    if (!fm_reg) begin
                        act_reg[sel]  <= 1'b1;
                        note_reg[sel] <= cur_note_reg;
                        ch_reg[sel]   <= cur_ch_reg;
                        lvl_reg[sel]  <= '0;
                        prog_reg[sel] <= '0;
                        if (sel_env < cfg.restart_threshold) env_reg[sel] <= '0;
                    end
                end
                pva_pkg::DP_SCAN_OFF: begin
                    if (rd_match && !rd_rel) begin
                        rel_reg[ix]  <= 1'b1;
                        lvl_reg[ix]  <= rd_env;
                        prog_reg[ix] <= '0;
                    end
                end
                pva_pkg::DP_TICK_RD: begin
                    if (rd_act) begin
                        if (!rd_rel) env_reg[ix] <= att_env;
                        else begin
                            prog_reg[ix] <= p_new;
                            if (p_new == pva_pkg::ONE_FX) begin
                                env_reg[ix] <= '0;
                                act_reg[ix] <= 1'b0;
                            end else begin
                                d_reg <= pva_pkg::ONE_FX - p_new;
                            end
                        end
                    end
                end
                pva_pkg::DP_TICK_SQ: prod_reg <= mul_p;
                pva_pkg::DP_TICK_LO: begin
                    prod_reg  <= mul_p;
                    sq_hi_reg <= prod_reg[32:16];
                end
                pva_pkg::DP_TICK_HI: begin
                    prod_reg <= mul_p;
                    lo_reg   <= prod_reg[PW-2:0];
                end
                pva_pkg::DP_TICK_WR: begin
                    env_reg[ix] <= rel_env;
                    if (rel_env <= cfg.end_threshold) act_reg[ix] <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        res_mask = '0;
        for (int i = 0; i < pva_pkg::MASK_N; i++) res_mask[i] = act_reg[i];
    end

    assign res_index  = res_index_reg;
    assign res_source = res_source_reg;

endmodule

`default_nettype wire

// ===== hdl/poly_voice_allocator_envelope.sv =====
// polyphonic voice allocator with stealing and per-voice envelopes
// note on: a scan over all NUM_VOICES voices, then claim, then finish
// note off: scan then finish; tick: a walk over the voices plus a multiplier pass and a
// write-back per fading voice (square then two half products on one 17x17 multiplier)
// one item in flight at a time; a stalled result holds the sequencer in finish
// synchronous active-low reset: all voices free, envelopes zero, registers to defaults
`timescale 1ns / 1ps
`default_nettype none

module poly_voice_allocator_envelope (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // item input
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [pva_pkg::KIND_W-1:0]    s_kind,
    input  wire logic [pva_pkg::CH_W-1:0]      s_midi_channel,
    input  wire logic [pva_pkg::NOTE_W-1:0]    s_note_number,
    // result output
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [pva_pkg::OIDX_W-1:0]         m_voice_index,
    output logic [pva_pkg::SRC_W-1:0]          m_claim_source,
    output logic [pva_pkg::MASK_W-1:0]         m_active_mask,
    // register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pva_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [pva_pkg::PDATA_W-1:0]   pwdata,
    output logic [pva_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    pva_pkg::pva_cfg_t     cfg_reg;
    pva_pkg::pva_cmd_t     cmd;
    pva_pkg::pva_status_t  status;

    logic                                idle;
    logic                                in_take;
    logic                                out_free;
    logic                                wr_en;
    logic [1:0]                          reg_sel;
    logic [pva_pkg::OIDX_W-1:0]          res_index;
    logic [pva_pkg::SRC_W-1:0]           res_source;
    logic [pva_pkg::MASK_W-1:0]          res_mask;

    logic                                m_valid_reg;
    logic [pva_pkg::OIDX_W-1:0]          m_index_reg;
    logic [pva_pkg::SRC_W-1:0]           m_source_reg;
    logic [pva_pkg::MASK_W-1:0]          m_mask_reg;

    // input transfer only when the sequencer is idle
    assign s_ready  = idle;
    assign in_take  = s_valid && idle;
    // output slot free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    // register port, always ready, word addressed
    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.attack_step       <= 17'd7;
            cfg_reg.release_step      <= 17'd3;
            cfg_reg.end_threshold     <= 17'd7;
            cfg_reg.restart_threshold <= 17'd66;
        end else if (wr_en) begin
            unique case (reg_sel)
                pva_pkg::REG_ATTACK_STEP:  cfg_reg.attack_step       <= pwdata[16:0];
                pva_pkg::REG_RELEASE_STEP: cfg_reg.release_step      <= pwdata[16:0];
                pva_pkg::REG_END_THR:      cfg_reg.end_threshold     <= pwdata[16:0];
                pva_pkg::REG_RESTART_THR:  cfg_reg.restart_threshold <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            pva_pkg::REG_ATTACK_STEP:  prdata = 32'(cfg_reg.attack_step);
            pva_pkg::REG_RELEASE_STEP: prdata = 32'(cfg_reg.release_step);
            pva_pkg::REG_END_THR:      prdata = 32'(cfg_reg.end_threshold);
            pva_pkg::REG_RESTART_THR:  prdata = 32'(cfg_reg.restart_threshold);
            default:                   prdata = '0;
        endcase
    end

    pva_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_take  (in_take),
        .in_kind  (s_kind),
        .out_free (out_free),
        .status   (status),
        .idle     (idle),
        .cmd      (cmd)
    );

    pva_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .cfg        (cfg_reg),
        .in_channel (s_midi_channel),
        .in_note    (s_note_number),
        .status     (status),
        .res_index  (res_index),
        .res_source (res_source),
        .res_mask   (res_mask)
    );

    // output register decouples the result from the next item's work
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.publish) begin
            m_valid_reg  <= 1'b1;
            m_index_reg  <= res_index;
            m_source_reg <= res_source;
            m_mask_reg   <= res_mask;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_voice_index  = m_index_reg;
    assign m_claim_source = m_source_reg;
    assign m_active_mask  = m_mask_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb_poly_voice_allocator_envelope.sv =====
// self-checking testbench for the polyphonic voice allocator with envelopes
// depends on hdl/pva_pkg.sv and hdl/poly_voice_allocator_envelope.sv
`timescale 1ns / 1ps

module tb_poly_voice_allocator_envelope;
    import pva_pkg::*;

    // spare kind code, changes nothing
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    // voice pool tracker: mirrors the allocator state and keeps expected results
    class voice_pool_tracker;
        typedef struct packed {
            logic [OIDX_W-1:0] vidx;
            logic [SRC_W-1:0]  src;
            logic [MASK_W-1:0] mask;
        } alloc_result_t;

        logic [ENV_W-1:0] atk, rel, endt, rst;
        bit               act [NUM_VOICES];
        bit               relg[NUM_VOICES];
        logic [NOTE_W-1:0] note[NUM_VOICES];
        logic [CH_W-1:0]  chan[NUM_VOICES];
        logic [ENV_W-1:0] env [NUM_VOICES];
        logic [ENV_W-1:0] lvl [NUM_VOICES];
        logic [ENV_W-1:0] prg [NUM_VOICES];
        alloc_result_t    pending[$];
        int               errors;

        function void reset_pool();
            atk = 7; rel = 3; endt = 7; rst = 66;
            for (int i = 0; i < NUM_VOICES; i++) begin
                act[i] = 0; relg[i] = 0; note[i] = 0; chan[i] = 0;
                env[i] = 0; lvl[i] = 0; prg[i] = 0;
            end
            pending.delete();
            errors = 0;
        endfunction

        function void set_reg(int idx, logic [31:0] v);
            case (idx)
                REG_ATTACK_STEP:  atk  = v[ENV_W-1:0];
                REG_RELEASE_STEP: rel  = v[ENV_W-1:0];
                REG_END_THR:      endt = v[ENV_W-1:0];
                default:          rst  = v[ENV_W-1:0];
            endcase
        endfunction

        // advance one voice by a sample tick
        function void tick_one(int i);
            logic [17:0] e;
            logic [17:0] p;
            logic [63:0] d, prod;
            if (!act[i]) return;
            if (!relg[i]) begin
                e = env[i] + atk;
                env[i] = (e > ONE_FX) ? ONE_FX : e[ENV_W-1:0];
            end else begin
                p = prg[i] + rel;
                if (p > ONE_FX) p = ONE_FX;
                prg[i] = p[ENV_W-1:0];
                if (p >= ONE_FX) begin
                    env[i] = 0;
                end else begin
                    d = 64'(ONE_FX - p);
                    prod = 64'(lvl[i]) * d * d;
                    env[i] = prod[32 +: ENV_W];
                end
                if (env[i] <= endt) act[i] = 0;
            end
        endfunction

        function void note_input(logic [KIND_W-1:0] k, logic [CH_W-1:0] c,
                                 logic [NOTE_W-1:0] n);
            int sel;
            logic [SRC_W-1:0] src;
            alloc_result_t r;
            sel = -1;
            src = SRC_NONE;
            if (k == KIND_NOTE_ON) begin
                for (int i = 0; i < NUM_VOICES; i++)
                    if (sel < 0 && act[i] && note[i] == n && chan[i] == c) begin
                        relg[i] = 0; sel = i; src = SRC_RETRIGGER;
                    end
                if (sel < 0)
                    for (int i = 0; i < NUM_VOICES; i++)
                        if (sel < 0 && !act[i]) begin
                            sel = i; src = SRC_FREE;
                        end
                if (sel < 0)
                    for (int i = 0; i < NUM_VOICES; i++)
                        if (relg[i] && (sel < 0 || env[i] < env[sel])) begin
                            sel = i; src = SRC_STOLE_REL;
                        end
                if (sel < 0)
                    for (int i = 0; i < NUM_VOICES; i++)
                        if (sel < 0 || env[i] < env[sel]) begin
                            sel = i; src = SRC_STOLE_SND;
                        end
                if (src != SRC_RETRIGGER) begin
                    act[sel] = 1; note[sel] = n; chan[sel] = c; relg[sel] = 0;
                    lvl[sel] = 0; prg[sel] = 0;
                    if (env[sel] < rst) env[sel] = 0;
                end
            end else if (k == KIND_NOTE_OFF) begin
                for (int i = 0; i < NUM_VOICES; i++)
                    if (act[i] && note[i] == n && chan[i] == c && !relg[i]) begin
                        relg[i] = 1; lvl[i] = env[i]; prg[i] = 0;
                    end
            end else if (k == KIND_TICK) begin
                for (int i = 0; i < NUM_VOICES; i++) tick_one(i);
            end
            r.vidx = (sel >= 0) ? sel[OIDX_W-1:0] : '0;
            r.src = src;
            r.mask = '0;
            for (int i = 0; i < NUM_VOICES && i < 8; i++) r.mask[i] = act[i];
            pending.push_back(r);
        endfunction

        function void check_result(logic [OIDX_W-1:0] v, logic [SRC_W-1:0] s,
                                   logic [MASK_W-1:0] m);
            alloc_result_t r;
            if (pending.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
                return;
            end
            r = pending.pop_front();
            if (r.vidx !== v) begin
                $error("voice_index expected %0d actual %0d", r.vidx, v); errors++;
            end
            if (r.src !== s) begin
                $error("claim_source expected %0d actual %0d", r.src, s); errors++;
            end
            if (r.mask !== m) begin
                $error("active_mask expected %02h actual %02h", r.mask, m); errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0, s_ready;
    logic [KIND_W-1:0] s_kind = '0;
    logic [CH_W-1:0]   s_midi_channel = '0;
    logic [NOTE_W-1:0] s_note_number = '0;
    logic m_valid, m_ready = 0;
    logic [OIDX_W-1:0] m_voice_index;
    logic [SRC_W-1:0]  m_claim_source;
    logic [MASK_W-1:0] m_active_mask;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    voice_pool_tracker pool = new();

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    poly_voice_allocator_envelope u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_midi_channel(s_midi_channel), .s_note_number(s_note_number),
        .m_valid(m_valid), .m_ready(m_ready), .m_voice_index(m_voice_index),
        .m_claim_source(m_claim_source), .m_active_mask(m_active_mask),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side: sample at rising edge, change ready at falling edge
    bit rx_stall_free = 0;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            pool.check_result(m_voice_index, m_claim_source, m_active_mask);
    end
    initial begin
        int g;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            g = rx_stall_free ? 0 : pick_gap();
            if (g == 0) begin
                m_ready <= 1;
            end else begin
                m_ready <= 0;
                repeat (g) @(negedge aclk);
                m_ready <= 1;
            end
        end
    end

    // one register write over the apb-style port, setup then access
    task automatic write_reg(int idx, logic [31:0] v);
        @(negedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= PADDR_W'(idx * 4); pwdata <= v;
        @(negedge aclk);
        penable <= 1;
        do @(posedge aclk); while (!pready);
        pool.set_reg(idx, v);
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // one input transfer; valid held with stable payload until accepted
    task automatic send_item(logic [KIND_W-1:0] k, logic [CH_W-1:0] c,
                             logic [NOTE_W-1:0] n, bit no_gap);
        int g;
        g = no_gap ? 0 : pick_gap();
        if (g > 0) begin
            @(negedge aclk);
            s_valid <= 0;
            repeat (g - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1; s_kind <= k; s_midi_channel <= c; s_note_number <= n;
        do @(posedge aclk); while (!s_ready);
        pool.note_input(k, c, n);
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_valid <= 0;
    endtask

    // wait for all results, then let the block settle before touching registers
    task automatic drain();
        drop_valid();
        while (pool.pending.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic random_config();
        int r;
        for (int i = 0; i < 4; i++) begin
            r = $urandom_range(0, 5);
            case (r)
                0: write_reg(i, (i >= 2) ? 0 : 1);
                1: write_reg(i, 32'h10000);
                2: write_reg(i, $urandom_range(1, 40));
                3: write_reg(i, $urandom_range(1, 2000));
                default: write_reg(i, $urandom_range(1, 65536));
            endcase
        end
    endtask

    // random traffic: mostly note on/off on a small note set, with ticks
    task automatic random_phase(int count);
        int r;
        logic [CH_W-1:0] c;
        logic [NOTE_W-1:0] n;
        logic [KIND_W-1:0] k;
        bit burst;
        burst = ($urandom_range(0, 3) == 0);
        for (int j = 0; j < count; j++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) begin
                c = CH_W'($urandom); n = NOTE_W'($urandom);
            end else begin
                c = $urandom_range(0, 1) ? 4'(0) : 4'(15);
                n = 7'($urandom_range(60, 66));
                if ($urandom_range(0, 7) == 0) n = $urandom_range(0, 1) ? 7'd0 : 7'd127;
            end
            if (r < 35) k = KIND_NOTE_ON;
            else if (r < 60) k = KIND_NOTE_OFF;
            else if (r < 97) k = KIND_TICK;
            else k = KIND_SPARE;
            send_item(k, c, n, burst);
        end
    endtask

    initial begin
        pool.reset_pool();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: fill the pool, retrigger, steal sounding, release, steal releasing
        for (int i = 0; i < 8; i++) send_item(KIND_NOTE_ON, 4'(i * 2), 7'(i * 18), 0);
        send_item(KIND_NOTE_ON, 4'd0, 7'd0, 0);
        send_item(KIND_NOTE_ON, 4'd15, 7'd127, 0);
        send_item(KIND_TICK, 4'd15, 7'd127, 0);
        send_item(KIND_NOTE_OFF, 4'd2, 7'd18, 0);
        send_item(KIND_NOTE_OFF, 4'd4, 7'd36, 0);
        send_item(KIND_TICK, 4'd0, 7'd0, 0);
        send_item(KIND_NOTE_ON, 4'd9, 7'd99, 0);
        send_item(KIND_NOTE_ON, 4'd10, 7'd100, 0);
        send_item(KIND_SPARE, 4'd15, 7'd127, 0);
        send_item(KIND_NOTE_OFF, 4'd15, 7'd127, 0);
        drain();

        // extremes: full attack in one tick, release to zero in one tick
        write_reg(REG_ATTACK_STEP, 32'h10000);
        write_reg(REG_RELEASE_STEP, 32'h10000);
        write_reg(REG_END_THR, 0);
        write_reg(REG_RESTART_THR, 32'h10000);
        send_item(KIND_TICK, 4'd0, 7'd0, 0);
        send_item(KIND_NOTE_OFF, 4'd0, 7'd0, 0);
        send_item(KIND_TICK, 4'd0, 7'd0, 0);
        send_item(KIND_NOTE_ON, 4'd0, 7'd0, 0);
        send_item(KIND_NOTE_OFF, 4'd6, 7'd54, 0);
        send_item(KIND_TICK, 4'd0, 7'd0, 0);
        drain();

        write_reg(REG_ATTACK_STEP, 1);
        write_reg(REG_RELEASE_STEP, 1);
        write_reg(REG_END_THR, 32'h10000);
        write_reg(REG_RESTART_THR, 0);
        random_phase(100);
        drain();

        for (int p = 0; p < 10; p++) begin
            random_config();
            random_phase(190);
            if (p == 4) rx_stall_free = 1;
            if (p == 6) rx_stall_free = 0;
            drain();
        end

        if (pool.errors == 0 && pool.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // hard limit on run time
    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end
endmodule
